// ----- hdl/rsacfr_pkg.sv -----
package rsacfr_pkg;

    // Configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_HEADER  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_STATION = 2'd1;

    localparam logic [7:0] HEADER_RST  = 8'hAA;
    localparam logic [7:0] STATION_RST = 8'hFE;

    // Frame byte positions that are kept
    localparam int POS_ADDR = 3;
    localparam int POS_CMD  = 4;
    localparam int POS_ARG  = 5;

    // Command and argument codes
    localparam logic [7:0] CMD_STOP  = 8'h00;
    localparam logic [7:0] CMD_RISE  = 8'h01;
    localparam logic [7:0] CMD_FALL  = 8'h02;
    localparam logic [7:0] CMD_LAMP  = 8'h05;
    localparam logic [7:0] ARG_ON    = 8'h01;
    localparam logic [7:0] ADDR_BCAST = 8'h00;

    // Latched command codes
    localparam logic [1:0] MOTOR_NONE = 2'd0;
    localparam logic [1:0] MOTOR_STOP = 2'd1;
    localparam logic [1:0] MOTOR_RISE = 2'd2;
    localparam logic [1:0] MOTOR_FALL = 2'd3;
    localparam logic [1:0] LAMP_NONE  = 2'd0;
    localparam logic [1:0] LAMP_ON    = 2'd1;
    localparam logic [1:0] LAMP_OFF   = 2'd2;

    // Queue between framer and decoder
    localparam int QDepth = 2;
    localparam int QPtrW  = 1;

    // Completed frame as handed from framer to decoder
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] arg;
    } t_frame;

    // Configuration values seen by framer and decoder
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] station_sw;
    } t_cfg;

endpackage

// ----- hdl/rsacfr_if.sv -----
// Received byte channel
interface rsacfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame result channel
interface rsacfr_res_if;
    logic       valid;
    logic       ready;
    logic       addressed;
    logic [1:0] motor_cmd;
    logic [1:0] lamp_cmd;

    modport source (output valid, output addressed, output motor_cmd, output lamp_cmd,
                    input ready);
    modport sink   (input valid, input addressed, input motor_cmd, input lamp_cmd,
                    output ready);
endinterface

// Configuration write channel
interface rsacfr_cfg_if import rsacfr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rsacfr_front.sv -----
module rsacfr_front import rsacfr_pkg::*; #(
    parameter int FRAME_LEN = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_header,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_ready,
    output logic       o_push,
    output t_frame     o_frame,
    input  logic       i_push_ready
);

    localparam int PosW = $clog2(FRAME_LEN + 1);
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LEN);

    logic            r_in_frame, n_in_frame;
    logic [PosW-1:0] r_pos, n_pos;
    logic [7:0]      r_addr, n_addr;
    logic [7:0]      r_cmd, n_cmd;
    logic [7:0]      r_arg, n_arg;
    logic [PosW-1:0] pos_inc;
    logic            acc;

    // Accept a byte whenever the queue has room for a possible frame
    assign o_ready = i_push_ready;
    assign acc     = i_valid && i_push_ready;
    assign pos_inc = r_pos + PosW'(1);

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_cmd      = r_cmd;
        n_arg      = r_arg;
        o_push     = 1'b0;
        if (acc) begin
            if (!r_in_frame) begin
                // hunt for the header byte
                if (i_rx_byte == i_header) begin
                    n_in_frame = 1'b1;
                    n_pos      = PosW'(1);
                end
            end else begin
                if (r_pos == PosW'(POS_ADDR)) n_addr = i_rx_byte;
                if (r_pos == PosW'(POS_CMD))  n_cmd  = i_rx_byte;
                if (r_pos == PosW'(POS_ARG))  n_arg  = i_rx_byte;
                n_pos = pos_inc;
                if (pos_inc == LastPos) begin
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                    o_push     = 1'b1;
                end
            end
        end
    end

    // Frame record includes the byte taken this cycle
    assign o_frame.addr = n_addr;
    assign o_frame.cmd  = n_cmd;
    assign o_frame.arg  = n_arg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_addr     <= '0;
            r_cmd      <= '0;
            r_arg      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_addr     <= n_addr;
            r_cmd      <= n_cmd;
            r_arg      <= n_arg;
        end
    end

endmodule

// ----- hdl/rsacfr_queue.sv -----
module rsacfr_queue import rsacfr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_push_ready,
    output logic   o_valid,
    output t_frame o_frame,
    input  logic   i_pop
);

    localparam int CntW = $clog2(QDepth + 1);

    t_frame          r_mem [QDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = (r_cnt != CntW'(QDepth));
    assign o_valid      = (r_cnt != '0);
    assign o_frame      = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + QPtrW'(1);
            if (do_pop)  r_rptr <= r_rptr + QPtrW'(1);
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

endmodule

// ----- hdl/rsacfr_back.sv -----
module rsacfr_back import rsacfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_station_sw,
    input  logic       i_valid,
    input  t_frame     i_frame,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_addressed,
    output logic [1:0] o_motor_cmd,
    output logic [1:0] o_lamp_cmd
);

    logic [1:0] r_motor_latch, n_motor_latch;
    logic [1:0] r_lamp_latch, n_lamp_latch;
    logic       r_out_valid;
    logic       r_addressed;
    logic       hit, arg_on;

    // Take a frame when the output register is free or being drained
    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign hit     = (i_frame.addr == ~i_station_sw) || (i_frame.addr == ADDR_BCAST);
    assign arg_on  = (i_frame.arg == ARG_ON);

    // Command decode against the current latches
    always_comb begin
        n_motor_latch = r_motor_latch;
        n_lamp_latch  = r_lamp_latch;
        if (hit) begin
            case (i_frame.cmd)
                CMD_STOP: n_motor_latch = MOTOR_STOP;
                CMD_RISE: n_motor_latch = arg_on ? MOTOR_RISE : MOTOR_STOP;
                CMD_FALL: n_motor_latch = arg_on ? MOTOR_FALL : MOTOR_STOP;
                CMD_LAMP: n_lamp_latch  = arg_on ? LAMP_ON : LAMP_OFF;
                default:  n_motor_latch = r_motor_latch;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_latch <= MOTOR_NONE;
            r_lamp_latch  <= LAMP_NONE;
            r_out_valid   <= 1'b0;
            r_addressed   <= 1'b0;
        end else if (o_pop) begin
            r_motor_latch <= n_motor_latch;
            r_lamp_latch  <= n_lamp_latch;
            r_out_valid   <= 1'b1;
            r_addressed   <= hit;
        end else if (i_ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_addressed = r_addressed;
    assign o_motor_cmd = r_motor_latch;
    assign o_lamp_cmd  = r_lamp_latch;

endmodule

// ----- hdl/rs485_addressed_command_frame_receiver_unit.sv -----
// RS-485 addressed command frame receiver.
// i_rx   : one received serial byte per request. While idle, bytes are
//          dropped until one equals the header register; that byte and the
//          following FRAME_LEN-1 bytes form a frame (bytes 3, 4, 5 are the
//          address, command and argument).
// o_res  : one result per completed frame: addressed flag and the motor and
//          lamp latches after the frame is applied. Idle bytes give none.
// i_cfg  : register writes, index 0 header byte, index 1 station switches;
//          always ready, other indexes are ignored.
// Throughput: one byte per cycle. A framer feeds a two-entry frame queue
// and a decoder with an output register; the framer stalls only when the
// queue is full, which takes the result sink holding off across three
// completed frames (one in the output register, two queued).
// The completed frame is written into the queue when its last byte is accepted,
// then registered into the output register once that is free or being drained.
// Reset (synchronous, active low) drops any partial frame, empties the
// queue, clears both command latches to none and restores the registers.
module rs485_addressed_command_frame_receiver_unit import rsacfr_pkg::*; #(
    parameter int FRAME_LEN = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsacfr_rx_if.sink    i_rx,
    rsacfr_res_if.source o_res,
    rsacfr_cfg_if.sink   i_cfg
);

    t_cfg   r_cfg;
    logic   push, push_ready, q_valid, pop;
    t_frame push_frame, q_frame;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header     <= HEADER_RST;
            r_cfg.station_sw <= STATION_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_HEADER)  r_cfg.header     <= i_cfg.data;
            if (i_cfg.index == REG_STATION) r_cfg.station_sw <= i_cfg.data;
        end
    end

    rsacfr_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_header     (r_cfg.header),
        .i_valid      (i_rx.valid),
        .i_rx_byte    (i_rx.rx_byte),
        .o_ready      (i_rx.ready),
        .o_push       (push),
        .o_frame      (push_frame),
        .i_push_ready (push_ready)
    );

    rsacfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_frame      (push_frame),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_frame      (q_frame),
        .i_pop        (pop)
    );

    rsacfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_station_sw (r_cfg.station_sw),
        .i_valid      (q_valid),
        .i_frame      (q_frame),
        .o_pop        (pop),
        .o_valid      (o_res.valid),
        .i_ready      (o_res.ready),
        .o_addressed  (o_res.addressed),
        .o_motor_cmd  (o_res.motor_cmd),
        .o_lamp_cmd   (o_res.lamp_cmd)
    );

endmodule

// ----- hdl/rsacfr_checker.sv -----
module rsacfr_checker import rsacfr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_motor_cmd,
    input logic [1:0] i_lamp_cmd
);

    logic r_motor_seen, r_lamp_seen;

    // Track whether a latch has ever been reported as set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_seen <= 1'b0;
            r_lamp_seen  <= 1'b0;
        end else if (i_res_valid && i_res_ready) begin
            if (i_motor_cmd != MOTOR_NONE) r_motor_seen <= 1'b1;
            if (i_lamp_cmd != LAMP_NONE)   r_lamp_seen  <= 1'b1;
        end
    end

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // Lamp latch has no fourth code
    a_lamp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_lamp_cmd != 2'd3)
        else $error("bad lamp code");

    // Motor latch never returns to none
    a_motor_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && r_motor_seen |-> i_motor_cmd != MOTOR_NONE)
        else $error("motor latch cleared");

    // Lamp latch never returns to none
    a_lamp_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && r_lamp_seen |-> i_lamp_cmd != LAMP_NONE)
        else $error("lamp latch cleared");

endmodule

bind rs485_addressed_command_frame_receiver_unit rsacfr_checker u_rsacfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_motor_cmd (o_res.motor_cmd),
    .i_lamp_cmd  (o_res.lamp_cmd)
);
